// ===== rtl/core/vsa_pkg.sv =====
// Shared types, constants and helpers for the voice stealing allocator.
// Used by vsa_cell, voice_stealing_allocator_core and vsa_checker.
package vsa_pkg;

    localparam int MAX_SOURCES = 32;
    localparam int IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
    localparam int KEY_W       = 1 + 8 + 16 + 32;
    localparam int LIMIT_W     = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_IDX_W   = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOICE_LIMIT = 1'b0,
        CFG_MUTED       = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_key key;
        t_idx idx;
    } t_vis;

    typedef struct packed {
        logic clear;
        logic rotate;
    } t_cell_ctl;

    function automatic t_key make_key(input logic playing, input logic [7:0] prio,
                                      input logic [15:0] gain, input logic [31:0] stamp);
        t_key k;
        k = '0;
        if (playing) begin
            k = {1'b1, prio, gain, stamp};
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/vsa_cell.sv =====
// One slot of the source chain: holds a stored source, a visitor that moves
// to the next slot on each rank step, and the slot's rank counter. Uses vsa_pkg.
module vsa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vsa_pkg::t_cell_ctl i_ctl,
    input  logic              i_load,
    input  vsa_pkg::t_key     i_key,
    input  logic              i_holds,
    input  vsa_pkg::t_idx     i_self_idx,
    input  vsa_pkg::t_cnt     i_count,
    input  vsa_pkg::t_vis     i_vis,
    output vsa_pkg::t_vis     o_vis,
    output vsa_pkg::t_cnt     o_rank,
    output logic              o_holds
);

    vsa_pkg::t_key r_key;
    logic          r_holds;
    vsa_pkg::t_vis r_vis;
    vsa_pkg::t_cnt r_rank;
    logic          vis_valid;
    logic          hit;

    assign vis_valid = vsa_pkg::CNT_W'(r_vis.idx) < i_count;
    assign hit       = vis_valid && ({r_vis.key, r_vis.idx} < {r_key, i_self_idx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis.idx <= i_self_idx;
        end else if (i_load) begin
            r_key     <= i_key;
            r_holds   <= i_holds;
            r_vis.key <= i_key;
            r_vis.idx <= i_self_idx;
        end else if (i_ctl.rotate) begin
            r_vis <= i_vis;
        end
        if (i_ctl.clear) begin
            r_rank <= '0;
        end else if (i_ctl.rotate) begin
            r_rank <= r_rank + vsa_pkg::CNT_W'(hit);
        end
    end

    assign o_vis   = r_vis;
    assign o_rank  = r_rank;
    assign o_holds = r_holds;

endmodule

// ===== rtl/core/voice_stealing_allocator_core.sv =====
// Top level of the voice stealing allocator: load/rank/emit control, config
// registers and output register around a ring of vsa_cell. Uses vsa_pkg.
//
// channel | direction | handshake               | payload
// in      | input     | i_in_valid / o_in_stall | playing .. last_source
// out     | output    | o_out_valid / i_out_stall | source_index .. last_result
// cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Load takes one source per cycle; a source beyond MAX_SOURCES is dropped.
// The last source starts ranking: the visitor ring rotates until each visitor has passed every slot.
// Then one result per stored source leaves per cycle from the output register
// unless i_out_stall holds it. Input stalls during rank/emit.
// Reset initialises control, config, output valid and visitor indexes; no clearing pass.
module voice_stealing_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_playing,
    input  logic [7:0]                    i_priority_req,
    input  logic [15:0]                   i_gain,
    input  logic [31:0]                   i_unstop_time,
    input  logic                          i_holds_voice,
    input  logic                          i_last_source,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vsa_pkg::OUT_IDX_W-1:0] o_source_index,
    output logic                          o_keeps_voice,
    output logic                          o_voice_stripped,
    output logic                          o_voice_granted,
    output logic                          o_last_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vsa_pkg::LIMIT_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_RANK,
        S_EMIT
    } t_state;

    t_state                        r_state;
    vsa_pkg::t_cnt                 r_count;
    vsa_pkg::t_cnt                 r_cut;
    vsa_pkg::t_idx                 r_step;
    vsa_pkg::t_idx                 r_emit;
    logic [vsa_pkg::LIMIT_W-1:0]   r_voice_limit;
    logic                          r_muted;
    logic                          r_out_valid;
    logic [vsa_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic                          r_out_keeps;
    logic                          r_out_stripped;
    logic                          r_out_granted;
    logic                          r_out_last;

    vsa_pkg::t_cell_ctl            cell_ctl;
    vsa_pkg::t_key                 in_key;
    vsa_pkg::t_vis                 vis_out  [vsa_pkg::MAX_SOURCES];
    vsa_pkg::t_cnt                 rank_out [vsa_pkg::MAX_SOURCES];
    logic                          holds_out[vsa_pkg::MAX_SOURCES];
    logic                          in_acc;
    logic                          has_room;
    vsa_pkg::t_cnt                 n_count;
    logic [vsa_pkg::LIMIT_W-1:0]   n_diff;
    logic                          out_adv;
    logic                          sel_keeps;
    logic                          sel_holds;
    logic                          emit_last;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign has_room    = r_count < vsa_pkg::CNT_W'(vsa_pkg::MAX_SOURCES);
    assign n_count     = has_room ? r_count + vsa_pkg::CNT_W'(1) : r_count;
    assign n_diff      = vsa_pkg::LIMIT_W'(n_count) - r_voice_limit;
    assign in_key      = vsa_pkg::make_key(i_playing, i_priority_req, i_gain,
                                           i_unstop_time);

    assign cell_ctl = {in_acc && i_last_source, r_state == S_RANK};

    for (genvar k = 0; k < vsa_pkg::MAX_SOURCES; k++) begin : g_cell
        vsa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_load     (in_acc && has_room && (r_count == vsa_pkg::CNT_W'(k))),
            .i_key      (in_key),
            .i_holds    (i_holds_voice),
            .i_self_idx (vsa_pkg::IDX_W'(k)),
            .i_count    (r_count),
            .i_vis      (vis_out[(k + vsa_pkg::MAX_SOURCES - 1) % vsa_pkg::MAX_SOURCES]),
            .o_vis      (vis_out[k]),
            .o_rank     (rank_out[k]),
            .o_holds    (holds_out[k])
        );
    end

    assign out_adv   = !r_out_valid || !i_out_stall;
    assign sel_holds = holds_out[r_emit];
    assign sel_keeps = !r_muted && (rank_out[r_emit] >= r_cut);
    assign emit_last = (vsa_pkg::CNT_W'(r_emit) + vsa_pkg::CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_count       <= '0;
            r_step        <= '0;
            r_emit        <= '0;
            r_voice_limit <= vsa_pkg::LIMIT_RESET;
            r_muted       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (vsa_pkg::t_cfg_reg'(i_cfg_index))
                    vsa_pkg::CFG_VOICE_LIMIT: r_voice_limit <= i_cfg_data;
                    vsa_pkg::CFG_MUTED:       r_muted       <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (i_last_source) begin
                            r_cut   <= (r_voice_limit >= vsa_pkg::LIMIT_W'(n_count)) ?
                                       '0 : vsa_pkg::CNT_W'(n_diff);
                            r_step  <= '0;
                            r_state <= S_RANK;
                        end
                    end
                end
                S_RANK: begin
                    r_step <= r_step + vsa_pkg::IDX_W'(1);
                    if (r_step == vsa_pkg::IDX_W'(vsa_pkg::MAX_SOURCES - 1)) begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_adv) begin
                        if (emit_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_emit <= r_emit + vsa_pkg::IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            if (r_state == S_EMIT && out_adv) begin
                r_out_valid    <= 1'b1;
                r_out_idx      <= vsa_pkg::OUT_IDX_W'(r_emit);
                r_out_keeps    <= sel_keeps;
                r_out_stripped <= sel_holds && !sel_keeps;
                r_out_granted  <= !sel_holds && sel_keeps;
                r_out_last     <= emit_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_source_index   = r_out_idx;
    assign o_keeps_voice    = r_out_keeps;
    assign o_voice_stripped = r_out_stripped;
    assign o_voice_granted  = r_out_granted;
    assign o_last_result    = r_out_last;

endmodule

// ===== rtl/core/vsa_checker.sv =====
// Port-level checks for voice_stealing_allocator_core, attached by bind.
// Uses vsa_pkg for port widths.
module vsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_last_source,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [vsa_pkg::OUT_IDX_W-1:0] o_source_index,
    input logic                          o_keeps_voice,
    input logic                          o_voice_stripped,
    input logic                          o_voice_granted,
    input logic                          o_last_result
);

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_source) |=> o_in_stall)
        else $error("input not stalled after last source");

    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid after reset");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            $stable({o_keeps_voice, o_voice_stripped, o_voice_granted, o_last_result}))
        else $error("stalled result flags changed");

    a_flags_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_voice_stripped && o_voice_granted) &&
                        !(o_keeps_voice && o_voice_stripped) &&
                        !(!o_keeps_voice && o_voice_granted))
        else $error("inconsistent voice flags");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_source_index))
        else $error("stalled result changed");

endmodule

bind voice_stealing_allocator_core vsa_checker u_vsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_last_source    (i_last_source),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_source_index   (o_source_index),
    .o_keeps_voice    (o_keeps_voice),
    .o_voice_stripped (o_voice_stripped),
    .o_voice_granted  (o_voice_granted),
    .o_last_result    (o_last_result)
);
